[sv/merge_sorter_top_defines.svh]
// assertion macros for the merge sorter
// used by merge_sorter_top only, no other dependencies
`ifndef MERGE_SORTER_TOP_DEFINES_SVH
`define MERGE_SORTER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define MS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ms_pkg.sv]
// shared constants and types for the merge sorter
// no dependencies
package ms_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned WIDTH_DEF = 32;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_LOAD  = 7'b0000001,
		S_SEG   = 7'b0000010,
		S_RD    = 7'b0000100,
		S_CMP   = 7'b0001000,
		S_ERD   = 7'b0010000,
		S_EOUT  = 7'b0100000,
		S_EWAIT = 7'b1000000
	} state_t;

endpackage

[sv/ms_ram.sv]
// simple dual-read, single-write memory with registered read data
// standalone, no package needed
module ms_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

[sv/merge_sorter_top.sv]
// merge sorter: collects a set of signed words, sorts them and streams them out
// depends on ms_pkg, ms_ram and merge_sorter_top_defines.svh
//
// usage
//  - input channel (value, last_item) with value_valid / value_stall. words are
//    taken one per cycle while the block is collecting. last_item closes the set.
//  - words past DEPTH are dropped; every result of that set then has overflow set.
//  - after the last word the block stalls its input, sorts the set bottom-up in
//    one shared memory holding two banks (ping-pong), one compare unit, then
//    streams the sorted words out on (sorted_value, last_result, overflow) with
//    result_valid / result_stall, lowest value first, equal values in arrival order.
//  - sequence for a set of n words: collect the words, then ceil(log2 n) merge
//    passes; each merge segment is set up in S_SEG, and each word of a pass is
//    read (S_RD) then compared and written (S_CMP) through the memory's registered
//    read port. each result is then read (S_ERD), loaded (S_EOUT) and held (S_EWAIT).
//  - a result holds in its output register for as long as result_stall is high;
//    the next result is fetched only after the current one is taken.
//  - reset clears the sequencer, word count, drop flag and output valid; the
//    memory is not cleared, only entries written by the current set are read.
module merge_sorter_top #(
	parameter int unsigned DEPTH = ms_pkg::DEPTH_DEF,
	parameter int unsigned WIDTH = ms_pkg::WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    value_valid,
	output logic                    value_stall,
	input  logic signed [WIDTH-1:0] value,
	input  logic                    last_item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [WIDTH-1:0] sorted_value,
	output logic                    last_result,
	output logic                    overflow
);

	import ms_pkg::*;

	`include "merge_sorter_top_defines.svh"

	// index, count, run and sum widths
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned RW = CW + 1;
	localparam int unsigned SW = CW + 2;

	state_t state_q;

	logic [CW-1:0] count_q;    // words stored so far
	logic          drop_q;     // a word of this set was dropped
	logic [CW-1:0] n_q;        // size of the set being sorted
	logic [RW-1:0] run_q;      // current run length
	logic [CW-1:0] lo_q;       // start of the current merge segment
	logic [CW-1:0] mid_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] l_q;        // left run head
	logic [CW-1:0] r_q;        // right run head
	logic [CW-1:0] k_q;        // destination index
	logic [CW-1:0] e_q;        // emit index
	logic          src_q;      // bank holding the current runs

	logic                    out_valid_q;
	logic signed [WIDTH-1:0] sorted_value_q;
	logic                    last_result_q;
	logic                    overflow_q;

	// memory ports
	logic                    wr_en;
	logic [AW:0]             wr_addr;
	logic [WIDTH-1:0]        wr_data;
	logic [AW:0]             rd_addr_a;
	logic [AW:0]             rd_addr_b;
	logic signed [WIDTH-1:0] rd_data_a;
	logic signed [WIDTH-1:0] rd_data_b;

	logic          accept;
	logic          has_room;
	logic [CW-1:0] n_nx;
	logic [SW-1:0] seg_mid_sum;
	logic [SW-1:0] seg_hi_sum;
	logic [CW-1:0] seg_mid;
	logic [CW-1:0] seg_hi;
	logic          left_live;
	logic          right_live;
	logic          take_l;
	logic [RW-1:0] run_dbl;
	logic [CW-1:0] k_inc;

	assign value_stall  = (state_q != S_LOAD);
	assign accept       = value_valid && !value_stall;
	assign has_room     = (count_q < CW'(DEPTH));
	assign n_nx         = has_room ? (count_q + CW'(1)) : count_q;

	// segment bounds, clipped to the set size
	assign seg_mid_sum  = SW'(lo_q) + SW'(run_q);
	assign seg_hi_sum   = SW'(lo_q) + SW'({run_q, 1'b0});
	assign seg_mid      = (seg_mid_sum < SW'(n_q)) ? seg_mid_sum[CW-1:0] : n_q;
	assign seg_hi       = (seg_hi_sum < SW'(n_q)) ? seg_hi_sum[CW-1:0] : n_q;

	// shared compare unit: left wins ties to keep the sort stable
	assign left_live    = (l_q < mid_q);
	assign right_live   = (r_q < hi_q);
	assign take_l       = left_live && (!right_live || (rd_data_a <= rd_data_b));
	assign run_dbl      = {run_q[RW-2:0], 1'b0};
	assign k_inc        = k_q + CW'(1);

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = {1'b0, count_q[AW-1:0]};
		wr_data   = value;
		rd_addr_a = {src_q, l_q[AW-1:0]};
		rd_addr_b = {src_q, r_q[AW-1:0]};
		unique case (state_q) inside
			S_LOAD: begin
				wr_en = accept && has_room;
			end
			S_CMP: begin
				wr_en   = 1'b1;
				wr_addr = {~src_q, k_q[AW-1:0]};
				wr_data = take_l ? rd_data_a : rd_data_b;
			end
			S_ERD, S_EOUT, S_EWAIT: begin
				rd_addr_a = {src_q, e_q[AW-1:0]};
			end
			default: begin
			end
		endcase
	end

	// each bank spans the full index range, so the bank bit never aliases
	ms_ram #(
		.DEPTH (2 * (2 ** AW)),
		.WIDTH (WIDTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			drop_q      <= 1'b0;
			n_q         <= '0;
			run_q       <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			l_q         <= '0;
			r_q         <= '0;
			k_q         <= '0;
			e_q         <= '0;
			src_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= n_nx;
						end else begin
							drop_q <= 1'b1;
						end
						if (last_item) begin
							n_q   <= n_nx;
							run_q <= RW'(1);
							lo_q  <= '0;
							e_q   <= '0;
							src_q <= 1'b0;
							// a single word needs no merging
							state_q <= (n_nx <= CW'(1)) ? S_ERD : S_SEG;
						end
					end
				end
				S_SEG: begin
					mid_q   <= seg_mid;
					hi_q    <= seg_hi;
					l_q     <= lo_q;
					r_q     <= seg_mid;
					k_q     <= lo_q;
					state_q <= S_RD;
				end
				S_RD: begin
					// read data for both heads lands in the next cycle
					state_q <= S_CMP;
				end
				S_CMP: begin
					k_q <= k_inc;
					if (take_l) begin
						l_q <= l_q + CW'(1);
					end else begin
						r_q <= r_q + CW'(1);
					end
					if (k_inc == hi_q) begin
						if (hi_q == n_q) begin
							// pass complete: swap banks, double the run
							src_q <= ~src_q;
							run_q <= run_dbl;
							lo_q  <= '0;
							if (run_dbl >= {1'b0, n_q}) begin
								e_q     <= '0;
								state_q <= S_ERD;
							end else begin
								state_q <= S_SEG;
							end
						end else begin
							lo_q    <= hi_q;
							state_q <= S_SEG;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EWAIT;
				end
				S_EWAIT: begin
					if (!result_stall) begin
						out_valid_q <= 1'b0;
						if (last_result_q) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							e_q     <= e_q + CW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// output word register, loaded once per result
	always_ff @(posedge clk) begin
		if (state_q == S_EOUT) begin
			sorted_value_q <= rd_data_a;
			last_result_q  <= ((e_q + CW'(1)) == n_q);
			overflow_q     <= drop_q;
		end
	end

	assign result_valid = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign last_result  = last_result_q;
	assign overflow     = overflow_q;

	// merge heads never run past their segment
	`MS_ASSERT_NOW(a_merge_bounds, clk, arst_n, (state_q == S_CMP),
		((k_q < hi_q) && (l_q <= mid_q) && (r_q <= hi_q) && (left_live || right_live)),
		"merge indices out of segment")

	// the emit index stays inside the stored set
	`MS_ASSERT_NOW(a_emit_range, clk, arst_n, out_valid_q,
		((e_q < n_q) && (n_q != '0)), "emit index beyond set size")

	// a closing word always leaves the collecting state
	`MS_ASSERT_NEXT(a_last_leaves_load, clk, arst_n, (accept && last_item),
		(state_q != S_LOAD), "sort did not start after last word")

endmodule
